/* rtl/rwcd_pkg.sv */
// Shared types and constants for the ray wall crossing detector.
// Depends on nothing; every other file in rtl/ imports this package.
package rwcd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd2;

    // Register reset values
    localparam logic [7:0] WALL_COUNT_RST   = 8'd0;
    localparam logic [3:0] GRID_COLUMNS_RST = 4'd9;
    localparam logic [3:0] GRID_ROWS_RST    = 4'd7;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // One wall table entry, start_x in the low nibble
    typedef struct packed {
        logic [3:0] end_y;
        logic [3:0] end_x;
        logic [3:0] start_y;
        logic [3:0] start_x;
    } wall_t;

    typedef struct packed {
        logic [11:0] ax;
        logic [11:0] ay;
        logic [11:0] bx;
        logic [11:0] by;
    } seg_t;

    typedef struct packed {
        logic       hit;
        logic       oob;
        logic [6:0] wall;
        seg_t       seg;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

/* rtl/rwcd_wall_check.sv */
// Crossing test and segment clipping of one step against one wall entry.
// Depends on rwcd_pkg (wall_t, seg_t).
module rwcd_wall_check #(
    parameter int FRAC_BITS = 8
) (
    input  rwcd_pkg::wall_t     wall,
    input  logic signed [13:0]  prev_x,
    input  logic signed [13:0]  prev_y,
    input  logic signed [13:0]  next_x,
    input  logic signed [13:0]  next_y,
    input  logic        [11:0]  half_len,
    output logic                crossed,
    output rwcd_pkg::seg_t      seg
);
    import rwcd_pkg::*;

    localparam int CW = (FRAC_BITS + 7 > 16) ? FRAC_BITS + 7 : 16;

    function automatic logic signed [CW-1:0] grid_fx(input logic [3:0] g);
        return $signed(CW'(g) << FRAC_BITS);
    endfunction

    function automatic logic signed [CW-1:0] clip_span(
        input logic signed [CW-1:0] v,
        input logic signed [CW-1:0] lo,
        input logic signed [CW-1:0] hi
    );
        logic signed [CW-1:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    logic signed [CW-1:0] px, py, nx, ny, hf;
    logic signed [CW-1:0] ax, ay, bx, by;
    logic                 vertical, horizontal;
    // along: coordinate running along the wall; across: the wall line axis
    logic signed [CW-1:0] along_n, along_p, along_lo, along_hi;
    logic signed [CW-1:0] across_n, across_p, line_c;
    logic                 skip_span, straddle;
    logic signed [CW-1:0] s0, s1;

    assign px = CW'(prev_x);
    assign py = CW'(prev_y);
    assign nx = CW'(next_x);
    assign ny = CW'(next_y);
    assign hf = $signed(CW'(half_len));

    assign ax = grid_fx(wall.start_x);
    assign ay = grid_fx(wall.start_y);
    assign bx = grid_fx(wall.end_x);
    assign by = grid_fx(wall.end_y);

    assign vertical   = (wall.start_x == wall.end_x);
    assign horizontal = !vertical && (wall.start_y == wall.end_y);

    always_comb
    begin
        if (vertical)
        begin
            along_n  = ny;
            along_p  = py;
            along_lo = ay;
            along_hi = by;
            across_n = nx;
            across_p = px;
            line_c   = ax;
        end
        else
        begin
            along_n  = nx;
            along_p  = px;
            along_lo = ax;
            along_hi = bx;
            across_n = ny;
            across_p = py;
            line_c   = ay;
        end
    end

    assign skip_span = (along_n < along_lo && along_p < along_lo) ||
                       (along_n > along_hi && along_p > along_hi);
    assign straddle  = (across_n <= line_c && across_p >= line_c) ||
                       (across_n >= line_c && across_p <= line_c);
    assign crossed   = (vertical || horizontal) && !skip_span && straddle;

    assign s0 = clip_span(along_n - hf, along_lo, along_hi);
    assign s1 = clip_span(along_n + hf, along_lo, along_hi);

    always_comb
    begin
        if (vertical)
        begin
            seg.ax = ax[11:0];
            seg.bx = bx[11:0];
            seg.ay = s0[11:0];
            seg.by = s1[11:0];
        end
        else
        begin
            seg.ay = ay[11:0];
            seg.by = by[11:0];
            seg.ax = s0[11:0];
            seg.bx = s1[11:0];
        end
    end

endmodule

/* rtl/ray_wall_crossing_detector.sv */
// Top level of the ray wall crossing detector: wall table memory, scan control,
// configuration registers and output register.
// Depends on rwcd_pkg and rwcd_wall_check.

// A load beat writes one entry of the wall table (a synchronous memory of
// MAX_WALLS 16-bit entries with one write and one read port) and returns an
// all-zero result beat; indexes at or beyond MAX_WALLS are dropped. A test beat
// first checks the new point against the grid extended by one unit on each
// side and, if it is outside, returns out_of_bounds at once. Otherwise the
// block walks the table from entry 0 over min(wall_count, MAX_WALLS) entries,
// one memory read per cycle, and evaluates each entry the cycle after its
// read; the first wall crossed ends the walk and is reported with its clipped
// segment. A load, an out-of-bounds test or an empty scan goes from accept to
// the result stage directly; a scan goes through accept, the read-then-evaluate
// walk and the hand-over of the result, and the walk through the single read
// port sets how long it takes. One item is in work at a time, and in_ready is
// high only while the block is idle; the output register lets the next item
// start while the previous result beat still waits for out_ready. The table
// contents are undefined after reset until loaded, and the registers take the
// values wall_count 0, grid_columns 9, grid_rows 7. Configuration writes go
// through at any clock edge with cfg_write high and must only be issued while
// the block is idle.
module ray_wall_crossing_detector #(
    parameter int MAX_WALLS = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [6:0]         wall_index,
    input  logic [3:0]         wall_start_x,
    input  logic [3:0]         wall_start_y,
    input  logic [3:0]         wall_end_x,
    input  logic [3:0]         wall_end_y,
    input  logic signed [13:0] prev_x,
    input  logic signed [13:0] prev_y,
    input  logic signed [13:0] next_x,
    input  logic signed [13:0] next_y,
    input  logic [11:0]        half_len,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               out_of_bounds,
    output logic [6:0]         hit_wall,
    output logic [11:0]        seg_ax,
    output logic [11:0]        seg_ay,
    output logic [11:0]        seg_bx,
    output logic [11:0]        seg_by
);
    import rwcd_pkg::*;

    localparam int AW    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W = AW + 1;                      // holds MAX_WALLS itself
    localparam int IXW   = ((AW > 7) ? AW : 7) + 1;     // load index compare width
    localparam int NW    = (CNT_W > 8) ? CNT_W : 8;     // scan length compare width
    localparam int CW    = (FRAC_BITS + 7 > 16) ? FRAC_BITS + 7 : 16;

    // Configuration registers
    logic [7:0] wall_count_reg;
    logic [3:0] grid_columns_reg;
    logic [3:0] grid_rows_reg;

    // Control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               rd_valid_reg;
    logic               out_valid_reg, out_valid_next;

    // Latched test beat and scan bookkeeping
    logic signed [13:0] px_reg, py_reg, nx_reg, ny_reg;
    logic [11:0]        half_reg;
    logic [CNT_W-1:0]   scan_len_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    wall_t              rd_data_reg;
    res_t               res_reg, res_next;
    res_t               out_reg;

    // Wall table
    wall_t              wall_mem [MAX_WALLS];

    logic               in_fire;
    logic               is_load;
    logic [IXW-1:0]     idx_ext;
    logic               load_ok;
    logic               mem_we;
    wall_t              wall_in;
    logic [NW-1:0]      wc_ext;
    logic [NW-1:0]      n_full;
    logic [CNT_W-1:0]   scan_len;
    logic signed [CW-1:0] nx_ext, ny_ext, one_fx, col_lim, row_lim;
    logic               oob;
    logic               mem_re;
    logic [CNT_W-1:0]   last_idx;
    logic               crossed;
    seg_t               seg;
    logic               scan_stop;
    logic               out_load;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign is_load  = (req_type == REQ_LOAD);

    // Load path: drop indexes beyond the table
    assign idx_ext = IXW'(wall_index);
    assign load_ok = idx_ext < IXW'(MAX_WALLS);
    assign mem_we  = in_fire && is_load && load_ok;
    assign wall_in = '{end_y: wall_end_y, end_x: wall_end_x,
                       start_y: wall_start_y, start_x: wall_start_x};

    // Scan length clamps to the table depth
    assign wc_ext   = NW'(wall_count_reg);
    assign n_full   = (wc_ext > NW'(MAX_WALLS)) ? NW'(MAX_WALLS) : wc_ext;
    assign scan_len = n_full[CNT_W-1:0];

    // Kill test on the new position against the grid plus one unit margin
    assign nx_ext  = CW'(next_x);
    assign ny_ext  = CW'(next_y);
    assign one_fx  = $signed(CW'(1) << FRAC_BITS);
    assign col_lim = $signed(CW'({1'b0, grid_columns_reg} + 5'd1) << FRAC_BITS);
    assign row_lim = $signed(CW'({1'b0, grid_rows_reg} + 5'd1) << FRAC_BITS);
    assign oob     = (nx_ext < -one_fx) || (ny_ext < -one_fx) ||
                     (nx_ext > col_lim) || (ny_ext > row_lim);

    // Evaluate the entry read in the previous cycle
    rwcd_wall_check #(
        .FRAC_BITS (FRAC_BITS)
    ) u_check (
        .wall     (rd_data_reg),
        .prev_x   (px_reg),
        .prev_y   (py_reg),
        .next_x   (nx_reg),
        .next_y   (ny_reg),
        .half_len (half_reg),
        .crossed  (crossed),
        .seg      (seg)
    );

    // The walk stops on the first crossed wall or after the last entry
    assign last_idx  = scan_len_reg - CNT_W'(1);
    assign scan_stop = rd_valid_reg && (crossed || rd_idx_reg == last_idx);
    assign mem_re    = (state_reg == ST_SCAN) && !scan_stop &&
                       (issue_cnt_reg < scan_len_reg);

    // Hand the finished result to the output register when it is free
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        res_next       = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next       = '0;
                    issue_cnt_next = '0;
                    if (is_load)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (oob)
                    begin
                        res_next.oob = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (scan_len == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (mem_re)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg && crossed)
                begin
                    res_next.hit  = 1'b1;
                    res_next.wall = 7'(rd_idx_reg);
                    res_next.seg  = seg;
                end
                if (scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= mem_re;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_count_reg   <= WALL_COUNT_RST;
            grid_columns_reg <= GRID_COLUMNS_RST;
            grid_rows_reg    <= GRID_ROWS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WALL_COUNT:   wall_count_reg   <= cfg_data;
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[3:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg       <= prev_x;
            py_reg       <= prev_y;
            nx_reg       <= next_x;
            ny_reg       <= next_y;
            half_reg     <= half_len;
            scan_len_reg <= scan_len;
        end
        if (mem_re)
        begin
            rd_idx_reg <= issue_cnt_reg;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Wall table: one write port for loads, one registered read for the walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wall_mem[idx_ext[AW-1:0]] <= wall_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= wall_mem[issue_cnt_reg[AW-1:0]];
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_reg.hit;
    assign out_of_bounds = out_reg.oob;
    assign hit_wall      = out_reg.wall;
    assign seg_ax        = out_reg.seg.ax;
    assign seg_ay        = out_reg.seg.ay;
    assign seg_bx        = out_reg.seg.bx;
    assign seg_by        = out_reg.seg.by;

endmodule

/* sim/tb.sv */
// Self-checking testbench for ray_wall_crossing_detector: a directed table, then random phases.
// It predicts result beats from its wall table and register copies; typed rows give their own.
// Depends on rwcd_pkg and the ray_wall_crossing_detector RTL.
module tb;
    import rwcd_pkg::*;

    localparam int WALLS          = 128;
    localparam int FRAC           = 8;
    localparam int ONE_FX         = 1 << FRAC;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 160;
    localparam int TIMEOUT_CYCLES = 1_500_000;

    localparam res_t RES_NONE = '0;
    localparam res_t RES_OOB  = {1'b0, 1'b1, 7'd0, 48'd0};

    // One input beat, one field per port
    typedef struct {
        logic               req;
        logic [6:0]         idx;
        logic [3:0]         sx;
        logic [3:0]         sy;
        logic [3:0]         ex;
        logic [3:0]         ey;
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic signed [13:0] nx;
        logic signed [13:0] ny;
        logic [11:0]        half;
    } beat_t;

    typedef enum logic {ROW_BEAT, ROW_CONFIG} row_kind_t;

    // A row of the directed table: either a beat or a register setting
    typedef struct {
        row_kind_t  kind;
        beat_t      b;
        bit         typed;
        res_t       want;
        logic [7:0] cfg_wc;
        logic [3:0] cfg_cols;
        logic [3:0] cfg_rows;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [6:0]         wall_index;
    logic [3:0]         wall_start_x;
    logic [3:0]         wall_start_y;
    logic [3:0]         wall_end_x;
    logic [3:0]         wall_end_y;
    logic signed [13:0] prev_x;
    logic signed [13:0] prev_y;
    logic signed [13:0] next_x;
    logic signed [13:0] next_y;
    logic [11:0]        half_len;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic               out_of_bounds;
    logic [6:0]         hit_wall;
    logic [11:0]        seg_ax;
    logic [11:0]        seg_ay;
    logic [11:0]        seg_bx;
    logic [11:0]        seg_by;

    // Our copy of the block state: wall table, which entries hold data, registers
    wall_t      wall_mem [WALLS];
    bit         written  [WALLS];
    logic [7:0] wall_count_q = WALL_COUNT_RST;
    logic [3:0] grid_cols_q  = GRID_COLUMNS_RST;
    logic [3:0] grid_rows_q  = GRID_ROWS_RST;

    // Crossing results predicted for accepted beats, oldest first
    res_t expected_crossings[$];
    row_t directed_rows[$];

    int  mismatches   = 0;
    int  loads_sent   = 0;
    int  tests_sent   = 0;
    int  hits_seen    = 0;
    int  kills_seen   = 0;
    bit  idle_on      = 1'b1;
    int  hold_request = 0;

    ray_wall_crossing_detector #(.MAX_WALLS(WALLS), .FRAC_BITS(FRAC)) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a beat
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("tb: done, errors");
        $finish;
    end

    function automatic int clamp_span(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    // Length of the run of written entries from index 0; scans never go past it
    function automatic int written_prefix();
        int p;
        p = 0;
        while (p < WALLS && written[p]) p++;
        return p;
    endfunction

    // Apply one beat to our state and return the result beat it causes
    function automatic res_t predict_crossing(input beat_t b);
        res_t  r;
        wall_t w;
        int    px, py, nx, ny, half, lim_x, lim_y, n;
        int    ax, ay, bx, by;
        r = '0;
        if (b.req == REQ_LOAD)
        begin
            wall_mem[b.idx] = {b.ey, b.ex, b.sy, b.sx};
            written[b.idx]  = 1'b1;
            return r;
        end
        px    = b.px;
        py    = b.py;
        nx    = b.nx;
        ny    = b.ny;
        half  = b.half;
        lim_x = (int'(grid_cols_q) + 1) << FRAC;
        lim_y = (int'(grid_rows_q) + 1) << FRAC;
        if (nx < -ONE_FX || ny < -ONE_FX || nx > lim_x || ny > lim_y)
        begin
            r.oob = 1'b1;
            return r;
        end
        n = (int'(wall_count_q) > WALLS) ? WALLS : int'(wall_count_q);
        for (int i = 0; i < n; i++)
        begin
            w  = wall_mem[i];
            ax = int'(w.start_x) << FRAC;
            ay = int'(w.start_y) << FRAC;
            bx = int'(w.end_x) << FRAC;
            by = int'(w.end_y) << FRAC;
            if (ax == bx)
            begin
                if ((ny < ay && py < ay) || (ny > by && py > by)) continue;
                if (!((nx <= ax && px >= ax) || (nx >= ax && px <= ax))) continue;
                r.seg.ax = 12'(ax);
                r.seg.bx = 12'(bx);
                r.seg.ay = 12'(clamp_span(ny - half, ay, by));
                r.seg.by = 12'(clamp_span(ny + half, ay, by));
            end
            else if (ay == by)
            begin
                if ((nx < ax && px < ax) || (nx > bx && px > bx)) continue;
                if (!((ny <= ay && py >= ay) || (ny >= ay && py <= ay))) continue;
                r.seg.ay = 12'(ay);
                r.seg.by = 12'(by);
                r.seg.ax = 12'(clamp_span(nx - half, ax, bx));
                r.seg.bx = 12'(clamp_span(nx + half, ax, bx));
            end
            else
            begin
                continue;
            end
            r.hit  = 1'b1;
            r.wall = 7'(i);
            return r;
        end
        return r;
    endfunction

    // Random beat: mostly loads of axis-aligned walls and steps aimed at scanned walls
    // or at random points near the grid, the rest raw noise with every bit free
    function automatic beat_t make_random_beat(input int scan_len);
        beat_t b;
        wall_t w;
        int    pick, shape, lo, hi, line, span_lo, span_hi, a, c, along, t;
        bit    vert;
        b.req  = REQ_TEST;
        b.idx  = 7'($urandom);
        b.sx   = 4'($urandom);
        b.sy   = 4'($urandom);
        b.ex   = 4'($urandom);
        b.ey   = 4'($urandom);
        b.px   = 14'($urandom);
        b.py   = 14'($urandom);
        b.nx   = 14'($urandom);
        b.ny   = 14'($urandom);
        b.half = 12'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 25)
        begin
            b.req = REQ_LOAD;
            lo    = written_prefix();
            if (lo < WALLS && $urandom_range(0, 1) == 1) b.idx = 7'(lo);
            shape = $urandom_range(0, 9);
            lo    = $urandom_range(0, 15);
            hi    = $urandom_range(lo, 15);
            if (shape < 4)
            begin
                b.ex = b.sx;
                b.sy = 4'(lo);
                b.ey = 4'(hi);
            end
            else if (shape < 8)
            begin
                b.ey = b.sy;
                b.sx = 4'(lo);
                b.ex = 4'(hi);
            end
            // otherwise keep raw endpoints: diagonal, reversed or point walls
            return b;
        end
        if (pick >= 90) return b;

        shape = $urandom_range(0, 9);
        if (shape == 0) b.half = 12'd0;
        else if (shape == 1) b.half = 12'hFFF;
        else b.half = 12'($urandom_range(0, 1023));

        w = wall_mem[(scan_len > 0) ? $urandom_range(0, scan_len - 1) : 0];
        if (scan_len > 0 && (w.start_x == w.end_x || w.start_y == w.end_y))
        begin
            vert    = (w.start_x == w.end_x);
            line    = (vert ? int'(w.start_x) : int'(w.start_y)) << FRAC;
            lo      = vert ? int'(w.start_y) : int'(w.start_x);
            hi      = vert ? int'(w.end_y) : int'(w.end_x);
            span_lo = ((lo < hi) ? lo : hi) << FRAC;
            span_hi = ((lo < hi) ? hi : lo) << FRAC;
            a       = line - $urandom_range(0, 400);
            c       = line + $urandom_range(0, 400);
            if ($urandom_range(0, 1) == 1)
            begin
                t = a;
                a = c;
                c = t;
            end
            along = span_lo - 200 + $urandom_range(0, span_hi - span_lo + 400);
            t     = along + $urandom_range(0, 300) - 150;
            if (vert)
            begin
                b.px = 14'(a);
                b.nx = 14'(c);
                b.ny = 14'(along);
                b.py = 14'(t);
            end
            else
            begin
                b.py = 14'(a);
                b.ny = 14'(c);
                b.nx = 14'(along);
                b.px = 14'(t);
            end
        end
        else
        begin
            b.px = 14'($urandom_range(0, 4352) - 256);
            b.py = 14'($urandom_range(0, 4352) - 256);
            b.nx = 14'($urandom_range(0, 4352) - 256);
            b.ny = 14'($urandom_range(0, 4352) - 256);
        end
        return b;
    endfunction

    // Offer one beat, hold it until accepted, then record what it must produce
    task automatic send_beat(input beat_t b, input bit typed, input res_t want);
        res_t predicted;
        while (idle_on && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req_type     <= b.req;
        wall_index   <= b.idx;
        wall_start_x <= b.sx;
        wall_start_y <= b.sy;
        wall_end_x   <= b.ex;
        wall_end_y   <= b.ey;
        prev_x       <= b.px;
        prev_y       <= b.py;
        next_x       <= b.nx;
        next_y       <= b.ny;
        half_len     <= b.half;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = predict_crossing(b);
        expected_crossings.push_back(typed ? want : predicted);
        if (b.req == REQ_LOAD)
        begin
            loads_sent++;
        end
        else
        begin
            tests_sent++;
            if (predicted.hit) hits_seen++;
            if (predicted.oob) kills_seen++;
        end
    endtask

    // Write all three registers on back-to-back edges; only call while the block is idle
    task automatic set_config(input logic [7:0] wc, input logic [3:0] cols,
                              input logic [3:0] rows);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WALL_COUNT;
        cfg_data  <= wc;
        @(posedge clk);
        cfg_index <= CFG_GRID_COLUMNS;
        cfg_data  <= {4'd0, cols};
        @(posedge clk);
        cfg_index <= CFG_GRID_ROWS;
        cfg_data  <= {4'd0, rows};
        @(posedge clk);
        cfg_write    <= 1'b0;
        wall_count_q = wc;
        grid_cols_q  = cols;
        grid_rows_q  = rows;
    endtask

    // Hold until every result beat has arrived and the block takes input again
    task automatic wait_idle();
        while (expected_crossings.size() != 0 || !in_ready) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_test(input int px, input int py, input int nx, input int ny,
                            input int half, input bit typed, input res_t want);
        row_t r;
        r       = '{kind: ROW_BEAT, default: '0};
        r.b.req = REQ_TEST;
        r.b.px  = 14'(px);
        r.b.py  = 14'(py);
        r.b.nx  = 14'(nx);
        r.b.ny  = 14'(ny);
        r.b.half = 12'(half);
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic add_load(input int idx, input int sx, input int sy, input int ex,
                            input int ey);
        row_t r;
        r       = '{kind: ROW_BEAT, default: '0};
        r.b.req = REQ_LOAD;
        r.b.idx = 7'(idx);
        r.b.sx  = 4'(sx);
        r.b.sy  = 4'(sy);
        r.b.ex  = 4'(ex);
        r.b.ey  = 4'(ey);
        r.typed = 1'b1;
        r.want  = RES_NONE;
        directed_rows.push_back(r);
    endtask

    task automatic add_config(input int wc, input int cols, input int rows);
        row_t r;
        r          = '{kind: ROW_CONFIG, default: '0};
        r.cfg_wc   = 8'(wc);
        r.cfg_cols = 4'(cols);
        r.cfg_rows = 4'(rows);
        directed_rows.push_back(r);
    endtask

    // Compare one result beat with the oldest prediction, field by field
    task automatic check_result();
        res_t got;
        res_t want;
        got.hit    = hit;
        got.oob    = out_of_bounds;
        got.wall   = hit_wall;
        got.seg.ax = seg_ax;
        got.seg.ay = seg_ay;
        got.seg.bx = seg_bx;
        got.seg.by = seg_by;
        if (expected_crossings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: result beat with nothing pending: hit %0d oob %0d wall %0d",
                         got.hit, got.oob, got.wall);
            return;
        end
        want = expected_crossings.pop_front();
        if (got.hit !== want.hit || got.oob !== want.oob || got.wall !== want.wall ||
            got.seg.ax !== want.seg.ax || got.seg.ay !== want.seg.ay ||
            got.seg.bx !== want.seg.bx || got.seg.by !== want.seg.by)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("tb: mismatch exp hit %0d oob %0d wall %0d seg %0d %0d %0d %0d",
                       want.hit, want.oob, want.wall, want.seg.ax, want.seg.ay,
                       want.seg.bx, want.seg.by);
                $display(" / got hit %0d oob %0d wall %0d seg %0d %0d %0d %0d",
                         got.hit, got.oob, got.wall,
                         got.seg.ax, got.seg.ay, got.seg.bx, got.seg.by);
            end
        end
    endtask

    // Result side: check each accepted beat, then pick out_ready for the next edge.
    // A hold request drops out_ready for a counted stretch so the block backs up.
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) check_result();
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !(idle_on && $urandom_range(0, 99) < 21);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain, verdict
    initial
    begin : stimulus
        beat_t      b;
        int         phase;
        int         sent;
        int         phase_len;
        int         prefix;
        int         choice;
        int         full_scans;
        logic [7:0] wc;
        logic [3:0] cols;
        logic [3:0] rows;

        phase      = 0;
        sent       = 0;
        full_scans = 0;
        foreach (written[k]) written[k] = 1'b0;

        // Drive every input to a known value and hold reset
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_WALL_COUNT;
        cfg_data     <= 8'd0;
        in_valid     <= 1'b0;
        req_type     <= REQ_LOAD;
        wall_index   <= 7'd0;
        wall_start_x <= 4'd0;
        wall_start_y <= 4'd0;
        wall_end_x   <= 4'd0;
        wall_end_y   <= 4'd0;
        prev_x       <= 14'sd0;
        prev_y       <= 14'sd0;
        next_x       <= 14'sd0;
        next_y       <= 14'sd0;
        half_len     <= 12'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: empty scan, grid 9 by 7, so the kill bounds are 2560 and 2048
        add_test(0, 0, 0, 0, 0, 1'b1, RES_NONE);
        add_test(0, 0, -257, 0, 0, 1'b1, RES_OOB);
        add_test(0, 0, -256, -256, 0, 1'b1, RES_NONE);
        add_test(0, 0, 2560, 2048, 0, 1'b1, RES_NONE);
        add_test(0, 0, 2561, 0, 0, 1'b1, RES_OOB);
        add_test(0, 0, 0, 2049, 0, 1'b1, RES_OOB);
        add_test(-8192, 8191, 8191, -8192, 4095, 1'b1, RES_OOB);
        // Walls: vertical, full-width horizontal, diagonal, reversed vertical,
        // point, reversed horizontal, and the last entry with every nibble high
        add_load(0, 3, 1, 3, 5);
        add_load(1, 0, 2, 15, 2);
        add_load(2, 1, 1, 4, 4);
        add_load(3, 5, 6, 5, 2);
        add_load(4, 7, 7, 7, 7);
        add_load(5, 12, 9, 4, 9);
        add_load(127, 15, 15, 15, 15);
        add_config(6, 15, 15);
        add_test(512, 768, 1024, 768, 256, 1'b0, RES_NONE);
        add_test(768, 1280, 768, 1280, 4095, 1'b0, RES_NONE);
        add_test(1536, 128, 1536, 700, 4095, 1'b0, RES_NONE);
        add_test(1152, 1024, 1408, 1024, 300, 1'b0, RES_NONE);
        add_test(1664, 1792, 1920, 1792, 100, 1'b0, RES_NONE);
        add_test(512, 1024, 1024, 2000, 200, 1'b0, RES_NONE);
        add_test(768, 512, 768, 512, 0, 1'b0, RES_NONE);
        add_test(-8192, 768, 1024, 768, 64, 1'b0, RES_NONE);
        // Grid 1 by 1: bounds at 512 in both axes
        add_config(0, 1, 1);
        add_test(0, 0, 512, 512, 0, 1'b1, RES_NONE);
        add_test(0, 0, 513, 0, 0, 1'b1, RES_OOB);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CONFIG)
            begin
                in_valid <= 1'b0;
                wait_idle();
                set_config(directed_rows[k].cfg_wc, directed_rows[k].cfg_cols,
                           directed_rows[k].cfg_rows);
            end
            else
            begin
                send_beat(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].want);
            end
        end
        in_valid <= 1'b0;

        // Random phases: drain, pick new registers, then a burst of beats. The scan
        // length never runs past the written prefix of the table.
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            prefix = written_prefix();
            if (prefix == WALLS && full_scans < 2)
            begin
                wc = (full_scans == 0) ? 8'd128 : 8'd255;
                full_scans++;
            end
            else
            begin
                choice = $urandom_range(0, 9);
                if (choice == 0) wc = 8'd0;
                else if (choice == 1) wc = 8'(prefix);
                else wc = 8'($urandom_range(0, prefix));
            end
            cols = ($urandom_range(0, 3) != 0) ? 4'd15 : 4'($urandom_range(0, 15));
            rows = ($urandom_range(0, 3) != 0) ? 4'd15 : 4'($urandom_range(0, 15));
            set_config(wc, cols, rows);

            // Every sixth phase runs with no idling on either side
            idle_on = (phase % 6) != 3;
            if (phase == 2) hold_request = HOLD_CYCLES;

            phase_len = $urandom_range(30, 70);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                b = make_random_beat((int'(wc) > WALLS) ? WALLS : int'(wc));
                send_beat(b, 1'b0, RES_NONE);
                sent++;
            end
            in_valid <= 1'b0;
            phase++;
        end

        // Let the last results come back, then watch a while for stray beats
        while (expected_crossings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d loads and %0d steps over %0d phases, %0d walls loaded in order",
                 loads_sent, tests_sent, phase, written_prefix());
        $display("tb: %0d steps hit a wall, %0d were killed off grid, %0d mismatches",
                 hits_seen, kills_seen, mismatches);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/rwcd_pkg.sv
rtl/rwcd_wall_check.sv
rtl/ray_wall_crossing_detector.sv
sim/tb.sv
